// File: hw/rtl/exptok_pkg.sv
// Shared types and constants for the expression tokenizer.
// Used by exptok_step, expression_tokenizer_core and exptok_checker; no dependencies.
package exptok_pkg;

    localparam int POS_BITS   = 16;
    localparam int VALUE_BITS = 63;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_CARET   = 8'h5E;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef enum logic [3:0] {
        KIND_ADD    = 4'd0,
        KIND_SUB    = 4'd1,
        KIND_MUL    = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_POW    = 4'd4,
        KIND_LPAREN = 4'd5,
        KIND_RPAREN = 4'd6,
        KIND_VAR    = 4'd7,
        KIND_NUM    = 4'd8,
        KIND_END    = 4'd9,
        KIND_BAD    = 4'd10,
        KIND_OVF    = 4'd11
    } token_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        token_kind_t           token_kind;
        logic [4:0]            letter_index;
        logic [VALUE_BITS-1:0] number_value;
        logic [POS_BITS-1:0]   token_position;
        logic                  last_of_run;
    } out_word_t;

    typedef struct packed {
        logic                  in_number;
        logic [VALUE_BITS-1:0] number_accumulator;
        logic                  number_overflowed;
        logic [POS_BITS-1:0]   number_start;
        logic [POS_BITS-1:0]   byte_position;
        logic                  error_seen;
    } state_t;

endpackage

// File: hw/rtl/expression_tokenizer_core.sv
// Top level of the expression tokenizer: input register, step logic and result register.
// Depends on exptok_pkg and exptok_step.
//
//   channel   ports             carries
//   input     s_valid/s_ready   s_word: one text byte and its end flag
//   output    m_valid/m_ready   m_word: one token with its start position
//
// A byte is taken into the input register and classified there; its tokens are
// written to the result register one per cycle while the output is not stalled.
// Throughput: one byte per cycle for bytes with zero or one token, output not
// stalled; a byte that yields k tokens (k is at most three) holds the input
// register until its last token is written to the result register.
// Reset clears all control state; the block is ready in the first cycle after reset.
// A stalled result register still takes a new byte into the empty input register.
module expression_tokenizer_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  exptok_pkg::in_word_t  s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output exptok_pkg::out_word_t m_word
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    exptok_pkg::in_word_t        in_word_reg;
    logic [1:0]                  phase_reg;
    logic [1:0]                  phase_next;
    exptok_pkg::state_t          state_reg;
    exptok_pkg::state_t          state_next;
    exptok_pkg::state_t          step_state;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    exptok_pkg::out_word_t       m_word_reg;
    exptok_pkg::out_word_t       m_word_next;

    exptok_pkg::out_word_t [2:0] token_list;
    logic [1:0]                  token_count;
    logic                        out_free;
    logic                        is_final;
    logic                        emit;
    logic                        retire;
    logic                        accept;

    exptok_step u_step (
        .word        (in_word_reg),
        .state       (state_reg),
        .token_list  (token_list),
        .token_count (token_count),
        .state_next  (step_state)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign is_final = (phase_reg == token_count - 2'd1);
    assign emit     = in_valid_reg && (token_count != 2'd0) && out_free;
    // A word leaves the input register once its last token is written, or at once
    // when it makes no token.
    assign retire   = in_valid_reg && ((token_count == 2'd0) || (out_free && is_final));
    assign s_ready  = !in_valid_reg || retire;
    assign accept   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        phase_next    = phase_reg;
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;

        if (retire) begin
            in_valid_next = 1'b0;
            phase_next    = 2'd0;
            state_next    = step_state;
        end else if (emit) begin
            phase_next = phase_reg + 2'd1;
        end
        if (accept) begin
            in_valid_next = 1'b1;
        end

        if (emit) begin
            m_valid_next             = 1'b1;
            m_word_next              = token_list[phase_reg];
            m_word_next.last_of_run  = is_final;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 2'd0;
            state_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_word_reg <= s_word;
        end
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// File: hw/rtl/exptok_step.sv
// Combinational tokenizer step: classifies one byte against the current state,
// lists up to three tokens in order and computes the next state. Uses exptok_pkg.
module exptok_step (
    input  exptok_pkg::in_word_t        word,
    input  exptok_pkg::state_t          state,
    output exptok_pkg::out_word_t [2:0] token_list,
    output logic [1:0]                  token_count,
    output exptok_pkg::state_t          state_next
);

    logic [7:0]                        c;
    logic                              last;
    logic                              is_digit;
    logic                              is_space;
    logic                              is_letter;
    logic                              op_hit;
    exptok_pkg::token_kind_t           op_kind;
    logic [3:0]                        digit;
    logic [exptok_pkg::POS_BITS-1:0]   pos_inc;
    logic                              start_new;
    logic [exptok_pkg::VALUE_BITS-1:0] acc_base;
    logic                              ovf_base;
    logic [exptok_pkg::VALUE_BITS+3:0] acc_wide;
    logic                              ovf_new;
    logic [exptok_pkg::VALUE_BITS-1:0] acc_new;
    logic [exptok_pkg::POS_BITS-1:0]   start_new_pos;
    logic [exptok_pkg::VALUE_BITS-1:0] num_acc;
    logic                              num_ovf;
    logic [exptok_pkg::POS_BITS-1:0]   num_pos;
    logic                              num_emit;
    logic                              err_after_num;
    logic                              own_emit;
    logic                              own_bad;
    logic                              end_emit;
    exptok_pkg::out_word_t             slot_num;
    exptok_pkg::out_word_t             slot_own;
    exptok_pkg::out_word_t             slot_end;

    assign c    = word.char_byte;
    assign last = word.end_of_input;

    assign is_digit  = (c >= exptok_pkg::CHAR_ZERO) && (c <= exptok_pkg::CHAR_NINE);
    assign is_space  = (c == exptok_pkg::CHAR_NEWLINE) || (c == exptok_pkg::CHAR_SPACE)
                    || (c == exptok_pkg::CHAR_TAB);
    assign is_letter = (c >= exptok_pkg::CHAR_LOWER_A) && (c <= exptok_pkg::CHAR_LOWER_Z);
    // The ASCII digits sit at 0x30..0x39, so the low nibble is the digit value.
    assign digit     = c[3:0];

    always_comb begin
        op_hit  = 1'b1;
        op_kind = exptok_pkg::KIND_ADD;
        unique case (c)
            exptok_pkg::CHAR_PLUS:   op_kind = exptok_pkg::KIND_ADD;
            exptok_pkg::CHAR_MINUS:  op_kind = exptok_pkg::KIND_SUB;
            exptok_pkg::CHAR_STAR:   op_kind = exptok_pkg::KIND_MUL;
            exptok_pkg::CHAR_SLASH:  op_kind = exptok_pkg::KIND_DIV;
            exptok_pkg::CHAR_CARET:  op_kind = exptok_pkg::KIND_POW;
            exptok_pkg::CHAR_LPAREN: op_kind = exptok_pkg::KIND_LPAREN;
            exptok_pkg::CHAR_RPAREN: op_kind = exptok_pkg::KIND_RPAREN;
            default:                 op_hit  = 1'b0;
        endcase
    end

    assign pos_inc = (state.byte_position == exptok_pkg::POS_MAX) ? state.byte_position
                   : state.byte_position + 1'b1;

    // Number accumulation: acc * 10 + digit as shift-and-add, with four guard bits
    // that flag a value past the 63-bit range.
    assign start_new     = !state.in_number;
    assign acc_base      = start_new ? '0 : state.number_accumulator;
    assign ovf_base      = start_new ? 1'b0 : state.number_overflowed;
    assign start_new_pos = start_new ? state.byte_position : state.number_start;
    assign acc_wide      = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                         + {{exptok_pkg::VALUE_BITS{1'b0}}, digit};
    assign ovf_new       = ovf_base || (acc_wide[exptok_pkg::VALUE_BITS+3:
                                                 exptok_pkg::VALUE_BITS] != 4'd0);
    assign acc_new       = ovf_new ? acc_base : acc_wide[exptok_pkg::VALUE_BITS-1:0];

    assign num_acc  = is_digit ? acc_new : state.number_accumulator;
    assign num_ovf  = is_digit ? ovf_new : state.number_overflowed;
    assign num_pos  = is_digit ? start_new_pos : state.number_start;
    assign num_emit = !state.error_seen && (is_digit ? last : state.in_number);

    assign err_after_num = num_emit && num_ovf;
    assign own_emit      = !state.error_seen && !is_digit && !err_after_num && !is_space;
    assign own_bad       = own_emit && !op_hit && !is_letter;
    assign end_emit      = !state.error_seen && last && !err_after_num && !own_bad;

    always_comb begin
        slot_num                = '0;
        slot_num.token_kind     = num_ovf ? exptok_pkg::KIND_OVF : exptok_pkg::KIND_NUM;
        slot_num.number_value   = num_ovf ? '0 : num_acc;
        slot_num.token_position = num_pos;

        slot_own                = '0;
        slot_own.token_position = state.byte_position;
        priority if (op_hit) begin
            slot_own.token_kind = op_kind;
        end else if (is_letter) begin
            slot_own.token_kind   = exptok_pkg::KIND_VAR;
            slot_own.letter_index = 5'(c - exptok_pkg::CHAR_LOWER_A);
        end else begin
            slot_own.token_kind = exptok_pkg::KIND_BAD;
        end

        slot_end                = '0;
        slot_end.token_kind     = exptok_pkg::KIND_END;
        slot_end.token_position = pos_inc;
    end

    // Pack the present tokens to the front, keeping their order.
    always_comb begin
        token_list[0] = num_emit ? slot_num : (own_emit ? slot_own : slot_end);
        token_list[1] = num_emit ? (own_emit ? slot_own : slot_end) : slot_end;
        token_list[2] = slot_end;
        token_count   = 2'({1'b0, num_emit} + {1'b0, own_emit} + {1'b0, end_emit});
    end

    always_comb begin
        state_next               = state;
        state_next.byte_position = pos_inc;
        if (last) begin
            state_next = '0;
        end else if (!state.error_seen) begin
            if (is_digit) begin
                state_next.in_number          = 1'b1;
                state_next.number_accumulator = acc_new;
                state_next.number_overflowed  = ovf_new;
                state_next.number_start       = start_new_pos;
            end else begin
                state_next.in_number  = 1'b0;
                state_next.error_seen = err_after_num || own_bad;
            end
        end
    end

endmodule

// File: hw/rtl/exptok_checker.sv
// Port-level checks for expression_tokenizer_core, attached with a bind statement.
// Depends on exptok_pkg.
module exptok_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input exptok_pkg::in_word_t  s_word,
    input logic                  m_valid,
    input logic                  m_ready,
    input exptok_pkg::out_word_t m_word
);

    // A waiting input word holds until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_word))
        else $error("input word changed while waiting");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Only variable tokens carry a letter, and it stays within a to z.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.token_kind == exptok_pkg::KIND_VAR) ?
                    (m_word.letter_index <= 5'd25) : (m_word.letter_index == 5'd0))
        else $error("letter index on wrong token");

    // Only number tokens carry a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.token_kind != exptok_pkg::KIND_NUM) |-> m_word.number_value == '0)
        else $error("number value on non-number token");

    // Reset leaves no result word standing.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind expression_tokenizer_core exptok_checker u_exptok_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

// File: sim/testbench.sv
// Self-checking testbench for expression_tokenizer_core: drives text bytes and checks tokens.
// Depends on exptok_pkg and the tokenizer RTL; a scoreboard class predicts every token.
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam longint unsigned VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0] OP_CHARS [7] = '{exptok_pkg::CHAR_PLUS, exptok_pkg::CHAR_MINUS,
                                            exptok_pkg::CHAR_STAR, exptok_pkg::CHAR_SLASH,
                                            exptok_pkg::CHAR_CARET, exptok_pkg::CHAR_LPAREN,
                                            exptok_pkg::CHAR_RPAREN};

    class token_scoreboard;
        exptok_pkg::out_word_t           pending[$];
        exptok_pkg::out_word_t           fresh[$];
        int                              errors;
        logic                            in_num;
        longint unsigned                 acc;
        logic                            overflowed;
        logic [exptok_pkg::POS_BITS-1:0] num_start;
        logic [exptok_pkg::POS_BITS-1:0] byte_pos;
        logic                            err_standing;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            in_num       = 1'b0;
            acc          = 0;
            overflowed   = 1'b0;
            num_start    = '0;
            byte_pos     = '0;
            err_standing = 1'b0;
        endfunction

        function void emit(exptok_pkg::token_kind_t kind, logic [4:0] letter,
                           logic [exptok_pkg::VALUE_BITS-1:0] value,
                           logic [exptok_pkg::POS_BITS-1:0] pos);
            exptok_pkg::out_word_t tok;
            tok.token_kind     = kind;
            tok.letter_index   = letter;
            tok.number_value   = value;
            tok.token_position = pos;
            tok.last_of_run    = 1'b0;
            fresh.push_back(tok);
        endfunction

        // An overflowed number turns into an error that blocks the rest of the expression.
        function void close_number();
            if (overflowed) begin
                emit(exptok_pkg::KIND_OVF, '0, '0, num_start);
                err_standing = 1'b1;
            end else begin
                emit(exptok_pkg::KIND_NUM, '0, acc[exptok_pkg::VALUE_BITS-1:0], num_start);
            end
            in_num = 1'b0;
        endfunction

        function void note_byte(exptok_pkg::in_word_t w);
            logic [7:0]                      c;
            logic                            last;
            logic [exptok_pkg::POS_BITS-1:0] pos;
            longint unsigned                 d;
            exptok_pkg::out_word_t           tok;
            c    = w.char_byte;
            last = w.end_of_input;
            pos  = byte_pos;
            fresh.delete();
            if (!err_standing) begin
                if (c >= exptok_pkg::CHAR_ZERO && c <= exptok_pkg::CHAR_NINE) begin
                    d = c - exptok_pkg::CHAR_ZERO;
                    if (!in_num) begin
                        in_num     = 1'b1;
                        num_start  = pos;
                        acc        = 0;
                        overflowed = 1'b0;
                    end
                    if (!overflowed) begin
                        if (acc > (VALUE_LIMIT - d) / 10)
                            overflowed = 1'b1;
                        else
                            acc = acc * 10 + d;
                    end
                    if (last)
                        close_number();
                end else begin
                    if (in_num)
                        close_number();
                    if (!err_standing) begin
                        case (c)
                            exptok_pkg::CHAR_NEWLINE, exptok_pkg::CHAR_SPACE,
                            exptok_pkg::CHAR_TAB: ;
                            exptok_pkg::CHAR_PLUS:   emit(exptok_pkg::KIND_ADD, '0, '0, pos);
                            exptok_pkg::CHAR_MINUS:  emit(exptok_pkg::KIND_SUB, '0, '0, pos);
                            exptok_pkg::CHAR_STAR:   emit(exptok_pkg::KIND_MUL, '0, '0, pos);
                            exptok_pkg::CHAR_SLASH:  emit(exptok_pkg::KIND_DIV, '0, '0, pos);
                            exptok_pkg::CHAR_CARET:  emit(exptok_pkg::KIND_POW, '0, '0, pos);
                            exptok_pkg::CHAR_LPAREN: emit(exptok_pkg::KIND_LPAREN, '0, '0, pos);
                            exptok_pkg::CHAR_RPAREN: emit(exptok_pkg::KIND_RPAREN, '0, '0, pos);
                            default: begin
                                if (c >= exptok_pkg::CHAR_LOWER_A &&
                                    c <= exptok_pkg::CHAR_LOWER_Z) begin
                                    emit(exptok_pkg::KIND_VAR,
                                         5'(c - exptok_pkg::CHAR_LOWER_A), '0, pos);
                                end else begin
                                    emit(exptok_pkg::KIND_BAD, '0, '0, pos);
                                    err_standing = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                if (last && !err_standing)
                    emit(exptok_pkg::KIND_END, '0, '0,
                         (pos == exptok_pkg::POS_MAX) ? exptok_pkg::POS_MAX : pos + 1'b1);
            end
            foreach (fresh[i]) begin
                tok = fresh[i];
                tok.last_of_run = (i == fresh.size() - 1);
                pending.push_back(tok);
            end
            if (last)
                clear();
            else if (byte_pos != exptok_pkg::POS_MAX)
                byte_pos = byte_pos + 1'b1;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_token(exptok_pkg::out_word_t got);
            exptok_pkg::out_word_t want;
            if (pending.size() == 0) begin
                report($sformatf("token kind %0d at position %0d with none expected",
                                 got.token_kind, got.token_position));
                return;
            end
            want = pending.pop_front();
            if (got.token_kind !== want.token_kind)
                report($sformatf("token_kind %0d, expected %0d", got.token_kind,
                                 want.token_kind));
            if (got.letter_index !== want.letter_index)
                report($sformatf("letter_index %0d, expected %0d", got.letter_index,
                                 want.letter_index));
            if (got.number_value !== want.number_value)
                report($sformatf("number_value %0d, expected %0d", got.number_value,
                                 want.number_value));
            if (got.token_position !== want.token_position)
                report($sformatf("token_position %0d, expected %0d", got.token_position,
                                 want.token_position));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0b, expected %0b", got.last_of_run,
                                 want.last_of_run));
        endtask
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    exptok_pkg::in_word_t  s_word  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    exptok_pkg::out_word_t m_word;

    token_scoreboard sb = new();
    bit         no_idle = 1'b0;
    int         stall_left = 0;
    int         random_bytes = 0;
    logic [7:0] expr_text[$];

    expression_tokenizer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #5 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_token(m_word);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!no_idle)
                stall_left = pick_gap();
        end
    end

    // Valid only drops when a gap follows, so back-to-back words keep it high.
    task automatic send_byte(logic [7:0] c, logic last);
        int                   gap;
        exptok_pkg::in_word_t w;
        w.char_byte    = c;
        w.end_of_input = last;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(w);
    endtask

    task automatic send_text(string s);
        foreach (s[k])
            send_byte(s[k], k == s.len() - 1);
    endtask

    task automatic append_string(string s);
        foreach (s[k])
            expr_text.push_back(s[k]);
    endtask

    task automatic append_number();
        int mode;
        int len;
        mode = $urandom_range(0, 9);
        if (mode == 6) begin
            append_string("9223372036854775807");
        end else if (mode == 7) begin
            append_string("9223372036854775808");
        end else if (mode == 9) begin
            expr_text.push_back(exptok_pkg::CHAR_ZERO);
        end else begin
            if (mode == 5)
                repeat ($urandom_range(1, 3)) expr_text.push_back(exptok_pkg::CHAR_ZERO);
            len = (mode == 8) ? $urandom_range(19, 25) : $urandom_range(1, 4);
            repeat (len)
                expr_text.push_back(exptok_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic build_expression();
        int r;
        expr_text.delete();
        repeat ($urandom_range(1, 10)) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                expr_text.push_back(OP_CHARS[$urandom_range(0, 6)]);
            end else if (r < 50) begin
                expr_text.push_back(exptok_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25)));
            end else if (r < 75) begin
                append_number();
            end else if (r < 90) begin
                case ($urandom_range(0, 2))
                    0:       expr_text.push_back(exptok_pkg::CHAR_SPACE);
                    1:       expr_text.push_back(exptok_pkg::CHAR_TAB);
                    default: expr_text.push_back(exptok_pkg::CHAR_NEWLINE);
                endcase
            end else if (r < 95) begin
                case ($urandom_range(0, 2))
                    0:       expr_text.push_back(CHAR_CR);
                    1:       expr_text.push_back(CHAR_VT);
                    default: expr_text.push_back(CHAR_FF);
                endcase
            end else begin
                expr_text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every operator, both letter extremes, the skipped bytes, and a number
        // closed by the end of input.
        send_text("+-*/^()az\n\t 0");
        // Carriage return is an error; the bytes after it, the end word too, yield nothing.
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_FF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Leading zeros, then one word that gives a number, its own token and the end token.
        send_text("007)");
        send_byte(CHAR_VT, 1'b1);
        send_text("a+12)");

        while (random_bytes < 270) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                build_expression();
                foreach (expr_text[i])
                    send_byte(expr_text[i], i == expr_text.size() - 1);
                random_bytes += expr_text.size();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                    random_bytes++;
                end
            end
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
